### src/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

### src/csw_pkg.sv
// Package with types, codes and defaults of the counting semaphore unit.
package csw_pkg;

    localparam int DEFAULT_MAX_WAITERS = 8;
    localparam int DEFAULT_COUNT_BITS  = 16;
    localparam int ID_BITS             = 16;
    localparam int OUT_COUNT_BITS      = 16;

    localparam logic [1:0] REQ_TRY  = 2'd0;
    localparam logic [1:0] REQ_WAIT = 2'd1;
    localparam logic [1:0] REQ_POST = 2'd2;

    localparam logic [2:0] ST_GRANTED = 3'd0;
    localparam logic [2:0] ST_REFUSED = 3'd1;
    localparam logic [2:0] ST_ADDED   = 3'd2;
    localparam logic [2:0] ST_ALREADY = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;
    localparam logic [2:0] ST_POSTED  = 3'd5;

    typedef enum logic {
        S_IDLE,
        S_DRAIN
    } state_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_APPEND,
        OP_SHIFT,
        OP_CLEAR
    } cell_op_t;

    typedef struct packed {
        logic               match;
        logic               full;
        logic               any_nz;
        logic               head_nz;
        logic               rest_nz;
        logic [ID_BITS-1:0] head_id;
    } chain_status_t;

endpackage

### src/counting_semaphore_waiters_unit.sv
// Counting semaphore with a bounded wait list, built as a row of list cells.
// Try, wait, and a post that finds no nonzero waiter give one beat in the cycle after
// start, one request per cycle. A post with waiters drains the list through cell 0, one
// slot per cycle: busy stays high until the last nonzero waiter is woken, and each
// wake beat is registered from the drain state that the post enters. A request is taken
// in any cycle with busy low. Reset clears the count, the list and the strobe.
module counting_semaphore_waiters_unit #(
    parameter int MAX_WAITERS = csw_pkg::DEFAULT_MAX_WAITERS,
    parameter int COUNT_BITS  = csw_pkg::DEFAULT_COUNT_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         req_type,
    input  logic [csw_pkg::ID_BITS-1:0]        requester_id,
    input  logic                               initial_count_we,
    input  logic [15:0]                        initial_count,
    output logic                               result_valid,
    output logic [2:0]                         status,
    output logic                               wake_valid,
    output logic [csw_pkg::ID_BITS-1:0]        wake_id,
    output logic [csw_pkg::OUT_COUNT_BITS-1:0] count_after,
    output logic                               last_result
);
    import csw_pkg::*;

    state_t              state_reg;
    state_t              state_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    cell_op_t            op;
    chain_status_t       stat;
    logic                accept;

    logic                res_fire;
    logic [2:0]          res_status;
    logic                res_wake;
    logic [ID_BITS-1:0]  res_id;
    logic                res_last;

    logic                result_valid_reg;
    logic [2:0]          status_reg;
    logic                wake_valid_reg;
    logic [ID_BITS-1:0]  wake_id_reg;
    logic                last_result_reg;

    logic [COUNT_BITS+15:0] cfg_ext;
    logic [COUNT_BITS+15:0] cnt_ext;

    assign accept  = start && (state_reg == S_IDLE);
    assign cfg_ext = {{COUNT_BITS{1'b0}}, initial_count};
    assign cnt_ext = {16'b0, count_reg};

    csw_chain #(
        .MAX_WAITERS (MAX_WAITERS)
    ) u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (op),
        .req_id (requester_id),
        .stat   (stat)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && req_type == REQ_POST && stat.any_nz)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (stat.head_nz && !stat.rest_nz)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op         = OP_HOLD;
        count_next = count_reg;
        res_fire   = 1'b0;
        res_status = ST_REFUSED;
        res_wake   = 1'b0;
        res_id     = '0;
        res_last   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (initial_count_we)
                begin
                    count_next = cfg_ext[COUNT_BITS-1:0];
                end
                if (accept)
                begin
                    res_fire = 1'b1;
                    priority if (req_type == REQ_POST)
                    begin
                        if (!(&count_reg))
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        if (stat.any_nz)
                        begin
                            // Wake results come from the drain that follows.
                            res_fire = 1'b0;
                        end
                        else
                        begin
                            op         = OP_CLEAR;
                            res_status = ST_POSTED;
                        end
                    end
                    else if (req_type == REQ_TRY || req_type == REQ_WAIT)
                    begin
                        priority if (|count_reg)
                        begin
                            count_next = count_reg - 1'b1;
                            res_status = ST_GRANTED;
                        end
                        else if (req_type == REQ_TRY)
                        begin
                            res_status = ST_REFUSED;
                        end
                        else if (stat.match)
                        begin
                            res_status = ST_ALREADY;
                        end
                        else if (stat.full)
                        begin
                            res_status = ST_FULL;
                        end
                        else
                        begin
                            op         = OP_APPEND;
                            res_status = ST_ADDED;
                        end
                    end
                    else
                    begin
                        res_status = ST_REFUSED;
                    end
                end
            end
            S_DRAIN:
            begin
                res_status = ST_POSTED;
                // Slots holding id zero shift past the head without a result.
                if (stat.head_nz)
                begin
                    res_fire = 1'b1;
                    res_wake = 1'b1;
                    res_id   = stat.head_id;
                    res_last = !stat.rest_nz;
                    op       = stat.rest_nz ? OP_SHIFT : OP_CLEAR;
                end
                else
                begin
                    op = OP_SHIFT;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            result_valid_reg <= res_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_fire)
        begin
            status_reg      <= res_status;
            wake_valid_reg  <= res_wake;
            wake_id_reg     <= res_id;
            last_result_reg <= res_last;
        end
    end

    assign busy         = (state_reg == S_DRAIN);
    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign wake_valid   = wake_valid_reg;
    assign wake_id      = wake_id_reg;
    assign count_after  = cnt_ext[OUT_COUNT_BITS-1:0];
    assign last_result  = last_result_reg;

endmodule

### src/csw_cell.sv
// One wait-list slot: holds a listed id and passes it toward the head.
module csw_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  csw_pkg::cell_op_t       op,
    input  logic                    prev_valid,
    input  logic                    next_valid,
    input  logic [csw_pkg::ID_BITS-1:0] next_id,
    input  logic [csw_pkg::ID_BITS-1:0] req_id,
    output logic                    valid,
    output logic [csw_pkg::ID_BITS-1:0] id,
    output logic                    match,
    output logic                    nz
);
    import csw_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [ID_BITS-1:0] id_reg;
    logic [ID_BITS-1:0] id_next;

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        unique case (op)
            OP_HOLD:
            begin
            end
            OP_APPEND:
            begin
                // Only the first free slot takes the new id.
                if (!valid_reg && prev_valid)
                begin
                    valid_next = 1'b1;
                    id_next    = req_id;
                end
            end
            OP_SHIFT:
            begin
                valid_next = next_valid;
                id_next    = next_id;
            end
            OP_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign valid = valid_reg;
    assign id    = id_reg;
    assign match = valid_reg && (id_reg == req_id);
    assign nz    = valid_reg && (id_reg != '0);

endmodule

### src/csw_chain.sv
// Row of wait-list cells with the flags the controller needs.
module csw_chain #(
    parameter int MAX_WAITERS = csw_pkg::DEFAULT_MAX_WAITERS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  csw_pkg::cell_op_t           op,
    input  logic [csw_pkg::ID_BITS-1:0] req_id,
    output csw_pkg::chain_status_t      stat
);
    import csw_pkg::*;

    logic [MAX_WAITERS-1:0] valid_vec;
    logic [MAX_WAITERS-1:0] match_vec;
    logic [MAX_WAITERS-1:0] nz_vec;
    logic [ID_BITS-1:0]     id_arr [MAX_WAITERS];

    genvar g;
    generate
        for (g = 0; g < MAX_WAITERS; g++)
        begin : g_cell
            logic               prev_v;
            logic               nxt_v;
            logic [ID_BITS-1:0] nxt_id;

            if (g == 0)
            begin : g_head
                assign prev_v = 1'b1;
            end
            else
            begin : g_body
                assign prev_v = valid_vec[g-1];
            end

            if (g == MAX_WAITERS - 1)
            begin : g_tail
                assign nxt_v  = 1'b0;
                assign nxt_id = '0;
            end
            else
            begin : g_link
                assign nxt_v  = valid_vec[g+1];
                assign nxt_id = id_arr[g+1];
            end

            csw_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .op         (op),
                .prev_valid (prev_v),
                .next_valid (nxt_v),
                .next_id    (nxt_id),
                .req_id     (req_id),
                .valid      (valid_vec[g]),
                .id         (id_arr[g]),
                .match      (match_vec[g]),
                .nz         (nz_vec[g])
            );
        end
    endgenerate

    always_comb
    begin
        stat.match   = |match_vec;
        stat.full    = valid_vec[MAX_WAITERS-1];
        stat.any_nz  = |nz_vec;
        stat.head_nz = nz_vec[0];
        stat.rest_nz = |(nz_vec >> 1);
        stat.head_id = id_arr[0];
    end

endmodule

### src/csw_checker.sv
// Port-level checker for the counting semaphore unit, bound to the top level.
`include "assert_macros.svh"

module csw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  req_type,
    input logic        result_valid,
    input logic [2:0]  status,
    input logic        wake_valid,
    input logic [15:0] wake_id,
    input logic        last_result
);
    import csw_pkg::*;

    // Any request other than a post answers in the next cycle with a single beat.
    `ASSERT_NEXT(a_quick_answer, clk, rst_n, start && !busy && req_type != REQ_POST, result_valid && last_result)

    // Only a post wakes, and never the empty id.
    `ASSERT_IMPLIES(a_wake_posted, clk, rst_n, result_valid && wake_valid, status == ST_POSTED && wake_id != 16'd0)

    // More wake beats to come keep the unit busy.
    `ASSERT_IMPLIES(a_more_busy, clk, rst_n, result_valid && !last_result, busy && wake_valid)

    // The drain ends exactly on its last beat.
    `ASSERT_IMPLIES(a_drain_end, clk, rst_n, $fell(busy), result_valid && last_result)

endmodule

bind counting_semaphore_waiters_unit csw_checker u_csw_checker (.*);

### tb/sv/semaphore_result_checker.sv
// Checker that predicts every result of the semaphore unit and compares it with the one seen.
module semaphore_result_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic [1:0]                         req_type,
    input  logic [csw_pkg::ID_BITS-1:0]        requester_id,
    input  logic                               initial_count_we,
    input  logic [15:0]                        initial_count,
    input  logic                               result_valid,
    input  logic [2:0]                         status,
    input  logic                               wake_valid,
    input  logic [csw_pkg::ID_BITS-1:0]        wake_id,
    input  logic [csw_pkg::OUT_COUNT_BITS-1:0] count_after,
    input  logic                               last_result,
    output int                                 mismatches,
    output int                                 outstanding,
    output int                                 requests_seen,
    output int                                 results_seen,
    output int                                 wakes_seen,
    output logic [5:0]                         statuses_seen
);
    import csw_pkg::*;

    localparam int LIST_DEPTH = DEFAULT_MAX_WAITERS;
    localparam int UNIT_BITS  = DEFAULT_COUNT_BITS;
    localparam logic [UNIT_BITS-1:0] UNITS_MAX = '1;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [2:0]                status;
        logic                      wake_valid;
        logic [ID_BITS-1:0]        wake_id;
        logic [OUT_COUNT_BITS-1:0] count_after;
        logic                      last_result;
    } sem_result_t;

    // Predicted semaphore state.
    logic [UNIT_BITS-1:0] units;
    int                   listed;
    logic [ID_BITS-1:0]   waiting_ids [LIST_DEPTH];

    sem_result_t expected_results [$];
    int          fail_total;
    int          request_total;
    int          result_total;
    int          wake_total;
    logic [5:0]  status_mask;

    function automatic void predict_request(input logic [1:0] kind,
                                            input logic [ID_BITS-1:0] id);
        sem_result_t r;
        logic        listed_already;
        int          last_pos;
        int          i;
        r = '0;
        r.last_result = 1'b1;
        listed_already = 1'b0;
        last_pos = -1;
        case (kind)
            REQ_TRY, REQ_WAIT:
            begin
                if (units != '0)
                begin
                    units = units - 1'b1;
                    r.status = ST_GRANTED;
                end
                else if (kind == REQ_TRY)
                begin
                    r.status = ST_REFUSED;
                end
                else
                begin
                    for (i = 0; i < listed; i++)
                        if (waiting_ids[i] == id)
                            listed_already = 1'b1;
                    // A listed id answers as already waiting even when the list is full.
                    if (listed_already)
                        r.status = ST_ALREADY;
                    else if (listed < LIST_DEPTH)
                    begin
                        waiting_ids[listed] = id;
                        listed++;
                        r.status = ST_ADDED;
                    end
                    else
                        r.status = ST_FULL;
                end
                r.count_after = OUT_COUNT_BITS'(units);
                expected_results.push_back(r);
            end
            REQ_POST:
            begin
                if (units != UNITS_MAX)
                    units = units + 1'b1;
                r.status = ST_POSTED;
                r.count_after = OUT_COUNT_BITS'(units);
                for (i = 0; i < listed; i++)
                    if (waiting_ids[i] != '0)
                        last_pos = i;
                // Waiters with id zero stay silent; the last nonzero one closes the post.
                if (last_pos < 0)
                    expected_results.push_back(r);
                else
                begin
                    for (i = 0; i <= last_pos; i++)
                        if (waiting_ids[i] != '0)
                        begin
                            r.wake_valid = 1'b1;
                            r.wake_id = waiting_ids[i];
                            r.last_result = (i == last_pos);
                            expected_results.push_back(r);
                        end
                end
                listed = 0;
            end
            default:
            begin
                r.status = ST_REFUSED;
                r.count_after = OUT_COUNT_BITS'(units);
                expected_results.push_back(r);
            end
        endcase
    endfunction

    function automatic void check_result();
        sem_result_t want;
        sem_result_t got;
        got.status = status;
        got.wake_valid = wake_valid;
        got.wake_id = wake_id;
        got.count_after = count_after;
        got.last_result = last_result;
        if (expected_results.size() == 0)
        begin
            fail_total++;
            if (fail_total <= REPORT_LIMIT)
                $display("Result with nothing expected: status %0d wake %b id %h count %0d last %b",
                         got.status, got.wake_valid, got.wake_id, got.count_after,
                         got.last_result);
        end
        else
        begin
            want = expected_results.pop_front();
            if (got.status !== want.status || got.wake_valid !== want.wake_valid ||
                got.wake_id !== want.wake_id || got.count_after !== want.count_after ||
                got.last_result !== want.last_result)
            begin
                fail_total++;
                if (fail_total <= REPORT_LIMIT)
                begin
                    $display("Result differs, expected: status %0d wake %b id %h count %0d last %b",
                             want.status, want.wake_valid, want.wake_id, want.count_after,
                             want.last_result);
                    $display("                 actual: status %0d wake %b id %h count %0d last %b",
                             got.status, got.wake_valid, got.wake_id, got.count_after,
                             got.last_result);
                end
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            units = '0;
            listed = 0;
            for (int i = 0; i < LIST_DEPTH; i++)
                waiting_ids[i] = '0;
            expected_results.delete();
            fail_total = 0;
            request_total = 0;
            result_total = 0;
            wake_total = 0;
            status_mask = '0;
        end
        else
        begin
            if (initial_count_we)
                units = UNIT_BITS'(initial_count);
            // Results come from earlier requests, so they are checked before a new one is predicted.
            if (result_valid)
            begin
                check_result();
                result_total++;
                if (wake_valid === 1'b1)
                    wake_total++;
                if (status < 3'd6)
                    status_mask[status] = 1'b1;
            end
            if (start && !busy)
            begin
                predict_request(req_type, requester_id);
                request_total++;
            end
        end
        mismatches    <= fail_total;
        outstanding   <= expected_results.size();
        requests_seen <= request_total;
        results_seen  <= result_total;
        wakes_seen    <= wake_total;
        statuses_seen <= status_mask;
    end

endmodule

### tb/sv/tb_top.sv
// Top of the semaphore unit testbench: clock, reset, request stimulus, count loads and verdict.
module tb_top;
    import csw_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_REQUESTS = 260;
    localparam int STALL_LIMIT     = 1000;
    localparam int SETTLE_CYCLES   = 20;
    localparam int POOL_SIZE       = 10;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic [1:0]                req_type = REQ_TRY;
    logic [ID_BITS-1:0]        requester_id = '0;
    logic                      initial_count_we = 1'b0;
    logic [15:0]               initial_count = '0;
    logic                      busy;
    logic                      result_valid;
    logic [2:0]                status;
    logic                      wake_valid;
    logic [ID_BITS-1:0]        wake_id;
    logic [OUT_COUNT_BITS-1:0] count_after;
    logic                      last_result;

    int         mismatches;
    int         outstanding;
    int         requests_seen;
    int         results_seen;
    int         wakes_seen;
    logic [5:0] statuses_seen;

    int                 count_loads = 0;
    int                 steady_run = 0;
    int                 stall_cycles = 0;
    logic [ID_BITS-1:0] id_pool [POOL_SIZE];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    counting_semaphore_waiters_unit uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .req_type         (req_type),
        .requester_id     (requester_id),
        .initial_count_we (initial_count_we),
        .initial_count    (initial_count),
        .result_valid     (result_valid),
        .status           (status),
        .wake_valid       (wake_valid),
        .wake_id          (wake_id),
        .count_after      (count_after),
        .last_result      (last_result)
    );

    semaphore_result_checker result_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .req_type         (req_type),
        .requester_id     (requester_id),
        .initial_count_we (initial_count_we),
        .initial_count    (initial_count),
        .result_valid     (result_valid),
        .status           (status),
        .wake_valid       (wake_valid),
        .wake_id          (wake_id),
        .count_after      (count_after),
        .last_result      (last_result),
        .mismatches       (mismatches),
        .outstanding      (outstanding),
        .requests_seen    (requests_seen),
        .results_seen     (results_seen),
        .wakes_seen       (wakes_seen),
        .statuses_seen    (statuses_seen)
    );

    // The run ends when no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no beat accepted for %0d cycles.", STALL_LIMIT);
            $display("counting_semaphore_waiters_unit: mismatch");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Mostly back-to-back or short gaps, a few long ones, and now and then a run with none.
    function automatic int draw_gap();
        int r;
        if (steady_run > 0)
        begin
            steady_run--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            steady_run = $urandom_range(8, 20);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    // Leaves start high after the beat so that the next request can follow at once.
    task automatic send_request(input logic [1:0] kind, input logic [ID_BITS-1:0] id);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req_type <= kind;
        requester_id <= id;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // The count is loaded only once every result is in and the unit has gone quiet.
    task automatic load_count(input logic [15:0] value);
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0 || busy);
        repeat (4) @(posedge clk);
        initial_count_we <= 1'b1;
        initial_count <= value;
        @(posedge clk);
        initial_count_we <= 1'b0;
        count_loads++;
    endtask

    function automatic logic [15:0] draw_load_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return 16'd0;
        if (r < 50)
            return 16'($urandom_range(1, 3));
        if (r < 60)
            return 16'hFFFF;
        if (r < 65)
            return 16'hFFFE;
        return 16'($urandom);
    endfunction

    task automatic send_random_request();
        int                 r;
        logic [1:0]         kind;
        logic [ID_BITS-1:0] id;
        r = $urandom_range(0, 99);
        if (r < 4)
            kind = REQ_UNUSED;
        else if (r < 19)
            kind = REQ_TRY;
        else if (r < 82)
            kind = REQ_WAIT;
        else
            kind = REQ_POST;
        if ($urandom_range(0, 99) < 80)
            id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            id = ID_BITS'($urandom);
        send_request(kind, id);
    endtask

    initial
    begin
        int sent;
        int phase_len;
        int r;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: refusals, list growth, duplicates, a full list, id zero,
        // the unused request kind, posts with and without waiters, and saturation.
        load_count(16'd0);
        send_request(REQ_TRY, 16'hFFFF);
        send_request(REQ_WAIT, 16'h0000);
        send_request(REQ_WAIT, 16'hFFFF);
        send_request(REQ_WAIT, 16'hFFFF);
        for (int i = 1; i <= 6; i++)
            send_request(REQ_WAIT, ID_BITS'(i));
        send_request(REQ_WAIT, 16'h7777);
        send_request(REQ_WAIT, 16'h0001);
        send_request(REQ_UNUSED, 16'hA5A5);
        send_request(REQ_POST, 16'h0000);
        send_request(REQ_WAIT, 16'h0009);
        send_request(REQ_WAIT, 16'h0000);
        send_request(REQ_POST, 16'h5A5A);
        send_request(REQ_POST, 16'h0000);
        send_request(REQ_TRY, 16'h0042);
        load_count(16'hFFFF);
        send_request(REQ_POST, 16'h0000);
        send_request(REQ_TRY, 16'h8000);
        send_request(REQ_POST, 16'h0000);
        load_count(16'd0);
        send_request(REQ_WAIT, 16'h0005);
        send_request(REQ_WAIT, 16'h0000);
        send_request(REQ_POST, 16'h0000);

        // Random part: each phase loads a count and works a small id pool so that
        // duplicates and full lists come up often.
        sent = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            load_count(draw_load_value());
            for (int j = 0; j < POOL_SIZE; j++)
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                    id_pool[j] = '0;
                else if (r < 20)
                    id_pool[j] = '1;
                else
                    id_pool[j] = ID_BITS'($urandom);
            end
            phase_len = $urandom_range(12, 30);
            for (int k = 0; k < phase_len && sent < RANDOM_REQUESTS; k++)
            begin
                send_random_request();
                sent++;
            end
        end

        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0 || busy);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d requests over %0d count loads; %0d results, %0d of them wakes.",
                 requests_seen, count_loads, results_seen, wakes_seen);
        $display("Status codes seen (bit 0 granted up to bit 5 posted): %b", statuses_seen);
        if (mismatches == 0 && outstanding == 0)
            $display("counting_semaphore_waiters_unit: match");
        else
            $display("counting_semaphore_waiters_unit: mismatch");
        $finish;
    end

endmodule
